// ===== rtl/core/mcd_pkg.sv =====
`timescale 1ns / 1ps

package mcd_pkg;

  localparam int MAX_SYMBOL_LEN = 5;
  localparam int SYM_BITS_W = 5;
  localparam int SYM_LEN_W = 3;
  localparam int RUN_W = 4;
  localparam int GAP_W = 4;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(3);
  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT = 8'h2e;
  localparam logic [7:0] CH_DASH = 8'h2d;
  localparam logic [7:0] CH_NONE = 8'h00;

  typedef struct packed {
    logic [SYM_BITS_W-1:0] symbol_bits;
    logic [SYM_LEN_W-1:0] symbol_length;
    logic symbol_invalid;
    logic in_symbol;
    logic [RUN_W-1:0] space_run;
    logic emitted_any;
    logic pending_space;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic message_end;
    logic last_of_run;
  } result_t;

  function automatic logic [7:0] lookup_symbol(input logic [SYM_LEN_W-1:0] len,
                                               input logic [SYM_BITS_W-1:0] bits);
    logic [7:0] ch;
    ch = CH_NONE;
    case ({len, bits})
      {3'd2, 5'd2}:  ch = 8'h41;
      {3'd4, 5'd1}:  ch = 8'h42;
      {3'd4, 5'd5}:  ch = 8'h43;
      {3'd3, 5'd1}:  ch = 8'h44;
      {3'd1, 5'd0}:  ch = 8'h45;
      {3'd4, 5'd4}:  ch = 8'h46;
      {3'd3, 5'd3}:  ch = 8'h47;
      {3'd4, 5'd0}:  ch = 8'h48;
      {3'd2, 5'd0}:  ch = 8'h49;
      {3'd4, 5'd14}: ch = 8'h4a;
      {3'd3, 5'd5}:  ch = 8'h4b;
      {3'd4, 5'd2}:  ch = 8'h4c;
      {3'd2, 5'd3}:  ch = 8'h4d;
      {3'd2, 5'd1}:  ch = 8'h4e;
      {3'd3, 5'd7}:  ch = 8'h4f;
      {3'd4, 5'd6}:  ch = 8'h50;
      {3'd4, 5'd11}: ch = 8'h51;
      {3'd3, 5'd2}:  ch = 8'h52;
      {3'd3, 5'd0}:  ch = 8'h53;
      {3'd1, 5'd1}:  ch = 8'h54;
      {3'd3, 5'd4}:  ch = 8'h55;
      {3'd4, 5'd8}:  ch = 8'h56;
      {3'd3, 5'd6}:  ch = 8'h57;
      {3'd4, 5'd9}:  ch = 8'h58;
      {3'd4, 5'd13}: ch = 8'h59;
      {3'd4, 5'd3}:  ch = 8'h5a;
      {3'd5, 5'd30}: ch = 8'h31;
      {3'd5, 5'd28}: ch = 8'h32;
      {3'd5, 5'd24}: ch = 8'h33;
      {3'd5, 5'd16}: ch = 8'h34;
      {3'd5, 5'd0}:  ch = 8'h35;
      {3'd5, 5'd1}:  ch = 8'h36;
      {3'd5, 5'd3}:  ch = 8'h37;
      {3'd5, 5'd7}:  ch = 8'h38;
      {3'd5, 5'd15}: ch = 8'h39;
      {3'd5, 5'd31}: ch = 8'h30;
      default:       ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/core/mcd_step.sv =====
`timescale 1ns / 1ps

module mcd_step import mcd_pkg::*; (
  input  dec_state_t       state,
  input  logic [7:0]       char_code,
  input  logic             end_of_message,
  input  logic [GAP_W-1:0] word_gap_length,
  output dec_state_t       state_next,
  output result_t          res0,
  output result_t          res1,
  output logic [1:0]       res_count
);

  logic ws;
  logic [7:0] ch_ws;
  logic [7:0] ch_eom;
  logic [RUN_W-1:0] run_inc;

  assign ws = (char_code == CH_SPACE) || (char_code >= 8'd9 && char_code <= 8'd13);
  assign ch_ws = state.symbol_invalid ? CH_NONE :
                 lookup_symbol(state.symbol_length, state.symbol_bits);

  always_comb begin
    dec_state_t s;
    logic [1:0] n;
    result_t r0;
    result_t r1;
    s = state;
    n = 2'd0;
    r0 = '0;
    r1 = '0;
    run_inc = (s.space_run == RUN_MAX) ? s.space_run : s.space_run + RUN_W'(1);
    ch_eom = CH_NONE;

    if (ws) begin
      if (s.in_symbol) begin
        s.in_symbol = 1'b0;
        s.symbol_bits = '0;
        s.symbol_length = '0;
        s.symbol_invalid = 1'b0;
        if (ch_ws != CH_NONE) begin
          if (s.pending_space && s.emitted_any) begin
            r0.out_char = CH_SPACE;
            r1.out_char = ch_ws;
            n = 2'd2;
          end else begin
            r0.out_char = ch_ws;
            n = 2'd1;
          end
          s.emitted_any = 1'b1;
          s.pending_space = 1'b0;
        end else if (s.emitted_any) begin
          s.pending_space = 1'b1;
        end
      end
      s.space_run = run_inc;
      if (s.space_run >= word_gap_length && s.emitted_any) begin
        s.pending_space = 1'b1;
      end
    end else begin
      s.space_run = '0;
      if (!s.in_symbol) begin
        s.in_symbol = 1'b1;
        s.symbol_bits = '0;
        s.symbol_length = '0;
        s.symbol_invalid = 1'b0;
      end
      if (char_code == CH_DOT || char_code == CH_DASH) begin
        if (s.symbol_length >= SYM_LEN_W'(MAX_SYMBOL_LEN)) begin
          s.symbol_invalid = 1'b1;
        end else begin
          if (char_code == CH_DASH) begin
            s.symbol_bits = s.symbol_bits | (SYM_BITS_W'(1) << s.symbol_length);
          end
          s.symbol_length = s.symbol_length + SYM_LEN_W'(1);
        end
      end else begin
        s.symbol_invalid = 1'b1;
      end
    end

    if (end_of_message) begin
      if (s.in_symbol && !s.symbol_invalid) begin
        ch_eom = lookup_symbol(s.symbol_length, s.symbol_bits);
      end
      // only the non-whitespace path can leave a symbol open here, so n is 0
      if (ch_eom != CH_NONE && s.pending_space && s.emitted_any) begin
        r0.out_char = CH_SPACE;
        r1.out_char = ch_eom;
        r1.message_end = 1'b1;
        n = 2'd2;
      end else if (n == 2'd0) begin
        r0.out_char = ch_eom;
        r0.message_end = 1'b1;
        n = 2'd1;
      end else if (n == 2'd1) begin
        r0.message_end = 1'b1;
      end else begin
        r1.message_end = 1'b1;
      end
      s = '0;
    end

    if (n == 2'd2) begin
      r1.last_of_run = 1'b1;
    end else begin
      r0.last_of_run = 1'b1;
    end

    state_next = s;
    res0 = r0;
    res1 = r1;
    res_count = n;
  end

endmodule

// ===== rtl/core/morse_code_decoder.sv =====
`timescale 1ns / 1ps

// Morse text decoder.
// Input stream: s_axis_tdata carries one text byte ('.', '-', whitespace or
// anything else), s_axis_tlast marks the final byte of a message.
// Output stream: m_axis_tdata is the decoded ASCII letter, digit or space
// (0 on a bare end-of-message), m_axis_tlast marks the final result of the
// message, m_axis_tuser marks the last result caused by one input request.
// cfg_wr_en / cfg_wr_data write the word-gap length; write only while idle.
// An accepted request waits in the input register, then its results move
// to the two-entry output buffer. A request gives zero, one or two results;
// one with zero or one result is taken every cycle while the receiver does
// not stall, one with two results holds the output until both are taken.
// Reset clears all decode state, sets the word gap to 3 and empties both
// pipeline stages. When the receiver stalls, the output buffer holds and
// the input register fills, then s_axis_tready drops.
module morse_code_decoder import mcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] char_code
  input  logic             s_axis_tlast,   // end_of_message
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] out_char
  output logic             m_axis_tlast,   // message_end
  output logic             m_axis_tuser,   // [0] last_of_run
  input  logic             cfg_wr_en,
  input  logic [GAP_W-1:0] cfg_wr_data
);

  logic [GAP_W-1:0] word_gap_length;
  dec_state_t state;
  dec_state_t state_next;

  logic in_valid;
  logic [7:0] in_char;
  logic in_eom;

  result_t buf0;
  result_t buf1;
  logic [1:0] buf_count;

  result_t res0;
  result_t res1;
  logic [1:0] res_count;

  logic pop;
  logic adv;

  assign pop = m_axis_tvalid && m_axis_tready;
  assign adv = in_valid && (buf_count == 2'd0 || (buf_count == 2'd1 && pop));
  assign s_axis_tready = !in_valid || adv;

  assign m_axis_tvalid = (buf_count != 2'd0);
  assign m_axis_tdata = buf0.out_char;
  assign m_axis_tlast = buf0.message_end;
  assign m_axis_tuser = buf0.last_of_run;

  mcd_step u_step (
    .state           (state),
    .char_code       (in_char),
    .end_of_message  (in_eom),
    .word_gap_length (word_gap_length),
    .state_next      (state_next),
    .res0            (res0),
    .res1            (res1),
    .res_count       (res_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      word_gap_length <= GAP_RESET;
    end else if (cfg_wr_en) begin
      word_gap_length <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char <= s_axis_tdata;
      in_eom <= s_axis_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (adv) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_count <= 2'd0;
    end else if (adv) begin
      buf_count <= res_count;
    end else if (pop) begin
      buf_count <= buf_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      buf0 <= res0;
      buf1 <= res1;
    end else if (pop) begin
      buf0 <= buf1;
    end
  end

endmodule
